/* rtl/dhcp_oar_pkg.sv */
// Package for the DHCP offer/ack responder: item types, register indexes,
// message codes and the fixed layout constants of request and reply.
// No dependencies.
`default_nettype none

package dhcp_oar_pkg;

  // Request parsing limits and layout (byte offsets into the BOOTP payload).
  localparam int unsigned MaxMessageBytesDef = 548;
  localparam int unsigned PosW               = 10;
  localparam int unsigned ChaddrAt           = 28;
  localparam int unsigned ChaddrLen          = 16;
  localparam int unsigned ChaddrIdxW         = $clog2(ChaddrLen);
  localparam int unsigned OptionsAt          = 236;
  localparam int unsigned WalkAt             = 240;
  localparam int unsigned MinLength          = 243;

  // Reply layout.
  localparam int unsigned ReplyBytes    = 274;
  localparam int unsigned ReplyWords    = 35;
  localparam int unsigned WordIdxW      = $clog2(ReplyWords);
  localparam int unsigned LastWordBytes = ReplyBytes - 8 * (ReplyWords - 1);
  localparam int unsigned ReplyPadBytes = ReplyWords * 8;

  // Register reset values.
  localparam logic [31:0] OfferedAddrRst = 32'hc0a8_0410;
  localparam logic [31:0] LeaseRst       = 32'd86400;

  // Option codes.
  localparam logic [7:0] OptPad       = 8'd0;
  localparam logic [7:0] OptSubnet    = 8'd1;
  localparam logic [7:0] OptRouter    = 8'd3;
  localparam logic [7:0] OptDns       = 8'd6;
  localparam logic [7:0] OptLease     = 8'd51;
  localparam logic [7:0] OptMsgType   = 8'd53;
  localparam logic [7:0] OptServerId  = 8'd54;
  localparam logic [7:0] OptEnd       = 8'd255;

  // Message types.
  localparam logic [7:0] MsgDiscover = 8'd1;
  localparam logic [7:0] MsgOffer    = 8'd2;
  localparam logic [7:0] MsgRequest  = 8'd3;
  localparam logic [7:0] MsgAck      = 8'd5;
  localparam logic [7:0] BootReply   = 8'd2;

  typedef enum logic [1:0] {
    CfgServerAddr  = 2'd0,
    CfgSubnetMask  = 2'd1,
    CfgOfferedAddr = 2'd2,
    CfgLeaseSecs   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhCode   = 2'd0,
    PhLength = 2'd1,
    PhSkip   = 2'd2,
    PhType   = 2'd3
  } opt_phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } req_item_t;

  typedef struct packed {
    logic [63:0] reply_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } reply_item_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h82;
      2'd2:    b = 8'h53;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/dhcp_offer_ack_responder.sv */
// DHCP offer/ack responder top level: request parser and reply word streamer.
// Depends on dhcp_oar_pkg.
`default_nettype none

// The block takes one request byte per cycle on the input channel and parses it
// on the fly: hardware type, address length, transaction id, flags and the
// 16-byte client hardware address are captured, the magic cookie is checked and
// the option list is walked for the first message-type option of length one. When the byte
// marked end_of_packet is accepted, a Discover starts an Offer and a Request
// starts an Ack; anything else gives nothing and the parser is ready for the
// next packet in the following cycle. A reply is 35 words of 64 bits (274 bytes,
// the last word carries 2 bytes), sent from a single output register at one word
// per cycle while the output side does not stall. The input stalls for the whole
// burst, since the reply is built from the fields of the request just parsed;
// outside a burst every cycle can take a byte. Bytes beyond MaxMessageBytes are
// not parsed, but end_of_packet on them still ends the packet. Configuration
// registers may be written only while no burst runs.
module dhcp_offer_ack_responder #(
  parameter int unsigned MaxMessageBytes = dhcp_oar_pkg::MaxMessageBytesDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Configuration write port.
  input  wire                        cfg_we_i,
  input  wire  [1:0]                 cfg_index_i,
  input  wire  [31:0]                cfg_data_i,
  // Request byte channel.
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  dhcp_oar_pkg::req_item_t in_item_i,
  // Reply word channel.
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output dhcp_oar_pkg::reply_item_t  out_item_o
);
  import dhcp_oar_pkg::*;

  // Configuration registers.
  logic [31:0] server_addr_q, subnet_mask_q, offered_addr_q, lease_q;

  // Parse state.
  logic [PosW-1:0] pos_q, pos_n, pos_d;
  opt_phase_e      phase_q, phase_n, phase_d;
  logic [7:0]      opt_code_q, opt_code_n, opt_code_d;
  logic [7:0]      opt_left_q, opt_left_n, opt_left_d;
  logic            stopped_q, stopped_n, stopped_d;
  logic            cookie_ok_q, cookie_ok_n, cookie_ok_d;
  logic [7:0]      found_type_q, found_type_n, found_type_d;

  // Captured request fields; these outlive the packet for the reply.
  logic [7:0]  hw_type_q, hw_type_d;
  logic [7:0]  hw_len_q, hw_len_d;
  logic [31:0] xid_q, xid_d;
  logic [15:0] flags_q, flags_d;
  logic [7:0]  chaddr_q [ChaddrLen];
  logic                  chaddr_we;
  logic [ChaddrIdxW-1:0] chaddr_idx;

  // Reply burst control.
  logic                busy_q, busy_d;
  logic [WordIdxW-1:0] word_idx_q, word_idx_d;
  logic [7:0]          reply_type_q, reply_type_d;
  logic                out_valid_q, out_valid_d;
  reply_item_t         out_item_q, out_item_d;

  logic       in_acc;
  logic       start;
  logic       load;
  logic [7:0] b;

  assign in_acc = in_valid_i && !in_stall_o;
  assign b      = in_item_i.payload_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_addr_q  <= '0;
      subnet_mask_q  <= '0;
      offered_addr_q <= OfferedAddrRst;
      lease_q        <= LeaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgServerAddr:  server_addr_q  <= cfg_data_i;
        CfgSubnetMask:  subnet_mask_q  <= cfg_data_i;
        CfgOfferedAddr: offered_addr_q <= cfg_data_i;
        CfgLeaseSecs:   lease_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Field capture, cookie check and option walk for one accepted byte.
  always_comb begin
    pos_n        = pos_q;
    phase_n      = phase_q;
    opt_code_n   = opt_code_q;
    opt_left_n   = opt_left_q;
    stopped_n    = stopped_q;
    cookie_ok_n  = cookie_ok_q;
    found_type_n = found_type_q;
    hw_type_d    = hw_type_q;
    hw_len_d     = hw_len_q;
    xid_d        = xid_q;
    flags_d      = flags_q;
    chaddr_we    = 1'b0;
    chaddr_idx   = ChaddrIdxW'(pos_q - PosW'(ChaddrAt));
    if (in_acc && (pos_q < PosW'(MaxMessageBytes))) begin
      pos_n = pos_q + PosW'(1);
      priority if (pos_q == PosW'(1)) begin
        hw_type_d = b;
      end else if (pos_q == PosW'(2)) begin
        hw_len_d = b;
      end else if (pos_q >= PosW'(4) && pos_q <= PosW'(7)) begin
        xid_d = {xid_q[23:0], b};
      end else if (pos_q == PosW'(10) || pos_q == PosW'(11)) begin
        flags_d = {flags_q[7:0], b};
      end else if (pos_q >= PosW'(ChaddrAt) && pos_q < PosW'(ChaddrAt + ChaddrLen)) begin
        chaddr_we = 1'b1;
      end else if (pos_q >= PosW'(OptionsAt) && pos_q < PosW'(WalkAt)) begin
        if (b != cookie_byte(2'(pos_q - PosW'(OptionsAt)))) cookie_ok_n = 1'b0;
      end else if (pos_q >= PosW'(WalkAt) && !stopped_q) begin
        unique case (phase_q)
          PhCode: begin
            if (b == OptEnd) begin
              stopped_n = 1'b1;
            end else if (b != OptPad) begin
              opt_code_n = b;
              phase_n    = PhLength;
            end
          end
          PhLength: begin
            opt_left_n = b;
            if (opt_code_q == OptMsgType && b == 8'd1) phase_n = PhType;
            else if (b == 8'd0)                        phase_n = PhCode;
            else                                       phase_n = PhSkip;
          end
          PhType: begin
            found_type_n = b;
            stopped_n    = 1'b1;
          end
          default: begin
            opt_left_n = opt_left_q - 8'd1;
            if (opt_left_n == 8'd0) phase_n = PhCode;
          end
        endcase
      end else begin
        // Bytes outside the captured fields carry nothing for the reply.
      end
    end
  end

  // The last byte decides on a reply and returns the parser to its start.
  always_comb begin
    start = in_acc && in_item_i.end_of_packet && (pos_n >= PosW'(MinLength)) &&
            cookie_ok_n && stopped_n &&
            (found_type_n == MsgDiscover || found_type_n == MsgRequest);
    reply_type_d = reply_type_q;
    if (start) reply_type_d = (found_type_n == MsgDiscover) ? MsgOffer : MsgAck;
    if (in_acc && in_item_i.end_of_packet) begin
      pos_d        = '0;
      phase_d      = PhCode;
      opt_code_d   = '0;
      opt_left_d   = '0;
      stopped_d    = 1'b0;
      cookie_ok_d  = 1'b1;
      found_type_d = '0;
    end else begin
      pos_d        = pos_n;
      phase_d      = phase_n;
      opt_code_d   = opt_code_n;
      opt_left_d   = opt_left_n;
      stopped_d    = stopped_n;
      cookie_ok_d  = cookie_ok_n;
      found_type_d = found_type_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= PhCode;
      opt_code_q   <= '0;
      opt_left_q   <= '0;
      stopped_q    <= 1'b0;
      cookie_ok_q  <= 1'b1;
      found_type_q <= '0;
      hw_type_q    <= '0;
      hw_len_q     <= '0;
      xid_q        <= '0;
      flags_q      <= '0;
      busy_q       <= 1'b0;
      word_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      phase_q      <= phase_d;
      opt_code_q   <= opt_code_d;
      opt_left_q   <= opt_left_d;
      stopped_q    <= stopped_d;
      cookie_ok_q  <= cookie_ok_d;
      found_type_q <= found_type_d;
      hw_type_q    <= hw_type_d;
      hw_len_q     <= hw_len_d;
      xid_q        <= xid_d;
      flags_q      <= flags_d;
      busy_q       <= busy_d;
      word_idx_q   <= word_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // The client address holds no reset value; every reply follows a packet
  // long enough to have written all of it.
  always_ff @(posedge clk_i) begin
    if (chaddr_we) chaddr_q[chaddr_idx] <= b;
  end

  always_ff @(posedge clk_i) begin
    reply_type_q <= reply_type_d;
    out_item_q   <= out_item_d;
  end

  // Reply image. Most bytes are constants; the rest come from registers.
  logic [7:0] r [ReplyPadBytes];

  always_comb begin
    for (int i = 0; i < ReplyPadBytes; i++) r[i] = 8'd0;
    r[0] = BootReply;
    r[1] = hw_type_q;
    r[2] = hw_len_q;
    for (int i = 0; i < 4; i++) begin
      r[4 + i]   = xid_q[31 - 8*i -: 8];
      r[16 + i]  = offered_addr_q[31 - 8*i -: 8];
      r[20 + i]  = server_addr_q[31 - 8*i -: 8];
      r[OptionsAt + i] = cookie_byte(2'(i));
      r[245 + i] = server_addr_q[31 - 8*i -: 8];
      r[251 + i] = subnet_mask_q[31 - 8*i -: 8];
      r[257 + i] = server_addr_q[31 - 8*i -: 8];
      r[263 + i] = server_addr_q[31 - 8*i -: 8];
      r[269 + i] = lease_q[31 - 8*i -: 8];
    end
    r[10] = flags_q[15:8];
    r[11] = flags_q[7:0];
    for (int i = 0; i < ChaddrLen; i++) r[ChaddrAt + i] = chaddr_q[i];
    r[240] = OptMsgType;  r[241] = 8'd1; r[242] = reply_type_q;
    r[243] = OptServerId; r[244] = 8'd4;
    r[249] = OptSubnet;   r[250] = 8'd4;
    r[255] = OptRouter;   r[256] = 8'd4;
    r[261] = OptDns;      r[262] = 8'd4;
    r[267] = OptLease;    r[268] = 8'd4;
    r[ReplyBytes - 1] = OptEnd;
  end

  // Burst control: one word moves into the output register whenever it is
  // empty or its word is being taken.
  logic last_idx;
  assign last_idx = (word_idx_q == WordIdxW'(ReplyWords - 1));
  assign load     = busy_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    busy_d      = busy_q;
    word_idx_d  = word_idx_q;
    out_valid_d = load || (out_valid_q && out_stall_i);
    out_item_d  = out_item_q;
    if (start) begin
      busy_d     = 1'b1;
      word_idx_d = '0;
    end
    if (load) begin
      for (int j = 0; j < 8; j++) begin
        out_item_d.reply_word[63 - 8*j -: 8] = r[{word_idx_q, 3'(j)}];
      end
      out_item_d.valid_bytes = last_idx ? 4'(LastWordBytes) : 4'd8;
      out_item_d.last_word   = last_idx;
      word_idx_d = word_idx_q + WordIdxW'(1);
      if (last_idx) busy_d = 1'b0;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A word that is not the final one can only sit in the output register
  // while the burst that produced it is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_word |-> busy_q)
    else $error("non-final reply word without a running burst");

  // The word counter never runs past the end of the reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> word_idx_q <= WordIdxW'(ReplyWords - 1))
    else $error("reply word index out of range");

  // A burst starts only right after the last byte of a packet was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(in_valid_i && !in_stall_o && in_item_i.end_of_packet))
    else $error("reply burst started without an end of packet");

endmodule

`default_nettype wire

/* test/dhcp_reply_check_pkg.sv */
// Scoreboard for the DHCP offer/ack responder testbench: a request parser and
// reply builder that predict every reply word, and the checker for them.
// Depends on dhcp_oar_pkg for the item types, register indexes and codes.
package dhcp_reply_check_pkg;

  import dhcp_oar_pkg::*;

  localparam logic [31:0] MagicCookie = 32'h6382_5363;

  class dhcp_reply_scoreboard;
    logic [31:0] server_addr;
    logic [31:0] subnet;
    logic [31:0] offered;
    logic [31:0] lease;

    logic [9:0]  pos;
    opt_phase_e  phase;
    logic [7:0]  opt_code;
    logic [7:0]  opt_left;
    logic [7:0]  msg_type;
    bit          walk_done;
    bit          cookie_ok;
    logic [7:0]  hw_type;
    logic [7:0]  hw_len;
    logic [31:0] xid;
    logic [15:0] flags;
    logic [7:0]  chaddr[ChaddrLen];

    reply_item_t reply_words_due[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned replies_due;

    function new();
      server_addr = '0;
      subnet      = '0;
      offered     = OfferedAddrRst;
      lease       = LeaseRst;
      hw_type     = '0;
      hw_len      = '0;
      xid         = '0;
      flags       = '0;
      foreach (chaddr[i]) chaddr[i] = '0;
      mismatches    = 0;
      words_checked = 0;
      replies_due   = 0;
      restart_parse();
    endfunction

    // The captured header fields survive a packet end; only the parse position, cookie check and walk restart.
    function void restart_parse();
      pos       = '0;
      phase     = PhCode;
      opt_code  = '0;
      opt_left  = '0;
      walk_done = 1'b0;
      cookie_ok = 1'b1;
      msg_type  = '0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [31:0] value);
      case (idx)
        CfgServerAddr:  server_addr = value;
        CfgSubnetMask:  subnet      = value;
        CfgOfferedAddr: offered     = value;
        default:        lease       = value;
      endcase
    endfunction

    // Parses one accepted request item and queues the 35 reply words when the
    // packet ends with a valid Discover or Request.
    function void note_request_byte(req_item_t it);
      logic [7:0]  b;
      logic [7:0]  img[ReplyPadBytes];
      logic [63:0] word;
      reply_item_t w;
      int          sh;
      b = it.payload_byte;
      if (pos < MaxMessageBytesDef) begin
        if (pos == 1) begin
          hw_type = b;
        end else if (pos == 2) begin
          hw_len = b;
        end else if (pos >= 4 && pos <= 7) begin
          xid = {xid[23:0], b};
        end else if (pos == 10 || pos == 11) begin
          flags = {flags[7:0], b};
        end else if (pos >= ChaddrAt && pos < ChaddrAt + ChaddrLen) begin
          chaddr[pos - ChaddrAt] = b;
        end else if (pos >= OptionsAt && pos < WalkAt) begin
          if (b != 8'(MagicCookie >> (8 * (WalkAt - 1 - pos)))) cookie_ok = 1'b0;
        end else if (pos >= WalkAt && !walk_done) begin
          case (phase)
            PhCode: begin
              if (b == OptEnd) begin
                walk_done = 1'b1;
              end else if (b != OptPad) begin
                opt_code = b;
                phase    = PhLength;
              end
            end
            PhLength: begin
              opt_left = b;
              if (opt_code == OptMsgType && b == 8'd1) phase = PhType;
              else if (b == 8'd0) phase = PhCode;
              else phase = PhSkip;
            end
            PhType: begin
              msg_type  = b;
              walk_done = 1'b1;
            end
            default: begin
              opt_left = opt_left - 1'b1;
              if (opt_left == 8'd0) phase = PhCode;
            end
          endcase
        end
        pos = pos + 1'b1;
      end
      if (!it.end_of_packet) return;

      if (pos >= MinLength && cookie_ok && walk_done &&
          (msg_type == MsgDiscover || msg_type == MsgRequest)) begin
        foreach (img[i]) img[i] = '0;
        img[0]  = BootReply;
        img[1]  = hw_type;
        img[2]  = hw_len;
        img[10] = flags[15:8];
        img[11] = flags[7:0];
        for (int k = 0; k < 4; k++) begin
          sh = 24 - 8 * k;
          img[4 + k]          = 8'(xid >> sh);
          img[16 + k]         = 8'(offered >> sh);
          img[20 + k]         = 8'(server_addr >> sh);
          img[OptionsAt + k]  = 8'(MagicCookie >> sh);
          img[245 + k]        = 8'(server_addr >> sh);
          img[251 + k]        = 8'(subnet >> sh);
          img[257 + k]        = 8'(server_addr >> sh);
          img[263 + k]        = 8'(server_addr >> sh);
          img[269 + k]        = 8'(lease >> sh);
        end
        for (int k = 0; k < ChaddrLen; k++) img[ChaddrAt + k] = chaddr[k];
        img[WalkAt]     = OptMsgType;
        img[WalkAt + 1] = 8'd1;
        img[WalkAt + 2] = (msg_type == MsgDiscover) ? MsgOffer : MsgAck;
        img[243] = OptServerId;
        img[244] = 8'd4;
        img[249] = OptSubnet;
        img[250] = 8'd4;
        img[255] = OptRouter;
        img[256] = 8'd4;
        img[261] = OptDns;
        img[262] = 8'd4;
        img[267] = OptLease;
        img[268] = 8'd4;
        img[ReplyBytes - 1] = OptEnd;
        for (int n = 0; n < ReplyWords; n++) begin
          word = '0;
          for (int j = 0; j < 8; j++) word = {word[55:0], img[8 * n + j]};
          w.reply_word  = word;
          w.valid_bytes = (n == ReplyWords - 1) ? 4'(LastWordBytes) : 4'd8;
          w.last_word   = (n == ReplyWords - 1);
          reply_words_due.push_back(w);
        end
        replies_due++;
      end
      restart_parse();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH %s: got %h, expected %h", what, got, want);
    endtask

    task check_reply(reply_item_t got);
      reply_item_t want;
      if (reply_words_due.size() == 0) begin
        report("reply word with no reply pending", got.reply_word, '0);
        return;
      end
      want = reply_words_due.pop_front();
      words_checked++;
      if (got.reply_word !== want.reply_word)
        report("reply_word", got.reply_word, want.reply_word);
      if (got.valid_bytes !== want.valid_bytes)
        report("valid_bytes", 64'(got.valid_bytes), 64'(want.valid_bytes));
      if (got.last_word !== want.last_word)
        report("last_word", 64'(got.last_word), 64'(want.last_word));
    endtask
  endclass

endpackage

/* test/tb_dhcp_offer_ack_responder.sv */
// Testbench top for the DHCP offer/ack responder: drives request packets and
// register writes, and checks every reply word against the scoreboard.
// Depends on dhcp_oar_pkg, dhcp_reply_check_pkg and the responder RTL.
module tb_dhcp_offer_ack_responder;
  timeunit 1ns;
  timeprecision 1ps;

  import dhcp_oar_pkg::*;
  import dhcp_reply_check_pkg::*;

  localparam int unsigned SettleCycles = 50;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_reg_e    cfg_index = CfgServerAddr;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  req_item_t   in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  reply_item_t out_item;

  // When set, the matching side runs without any idle cycles.
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  // The request packet that is being built and then sent.
  logic [7:0]  pkt[$];
  int unsigned bytes_sent   = 0;
  int unsigned packets_sent = 0;

  dhcp_reply_scoreboard sb = new();

  dhcp_offer_ack_responder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial forever #1 clk = ~clk;

  // Both channels are sampled at the rising edge, before any nonblocking
  // update of that edge lands, so the monitor sees exactly what the block saw.
  // A request item is predicted before a reply word of the same edge is
  // checked; that word can only belong to an earlier packet anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request_byte(in_item);
      if (out_valid && !out_stall) sb.check_reply(out_item);
    end
  end

  // Reply side back-pressure. Every reply word draws a random stall, possibly
  // none; now and then the side switches into a calm stretch without any
  // stall, so stalls land on every word of a burst as well as between bursts.
  initial begin : reply_backpressure
    int hold;
    forever begin
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Sends one request item after a random gap. The task returns in the time
  // step of the accepting edge, so a following call may put the next item
  // out at once with valid still high.
  task automatic send_item(req_item_t it);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends the built packet with end_of_packet on its final byte. About a
  // quarter of the packets go out back to back without idle cycles.
  task automatic send_request();
    req_item_t it;
    in_calm = ($urandom_range(0, 3) == 0);
    foreach (pkt[i]) begin
      it.payload_byte  = pkt[i];
      it.end_of_packet = (i == pkt.size() - 1);
      send_item(it);
    end
    bytes_sent += pkt.size();
    packets_sent++;
  endtask

  // Lowers valid and waits until every predicted reply word has been seen.
  // The first edge lets the monitor take in the packet's final item.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.reply_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_register(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Fixed header of 236 bytes (random, or a constant byte when fill is not
  // negative) followed by a correct magic cookie.
  function automatic void start_request(int fill);
    pkt.delete();
    repeat (OptionsAt) pkt.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    for (int k = 0; k < 4; k++) pkt.push_back(8'(MagicCookie >> (24 - 8 * k)));
  endfunction

  function automatic void add_type(logic [7:0] t);
    pkt.push_back(OptMsgType);
    pkt.push_back(8'd1);
    pkt.push_back(t);
  endfunction

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The shortest packet that can get a reply, with the registers at their
    // reset values: a bare Discover option right after the cookie.
    start_request(-1);
    add_type(MsgDiscover);
    send_request();
    // A packet of a single byte gives nothing.
    pkt.delete();
    pkt.push_back(8'($urandom));
    send_request();
    // A packet that ends long before the cookie gives nothing either.
    pkt.delete();
    repeat ($urandom_range(2, 40)) pkt.push_back(8'($urandom));
    send_request();

    // Wait for the Offer, then give every register a new value.
    drain();
    write_reg(CfgServerAddr, $urandom);
    write_reg(CfgSubnetMask, $urandom);
    write_reg(CfgOfferedAddr, $urandom);
    write_reg(CfgLeaseSecs, $urandom);
    // Pads, a foreign option, a message-type option of length 2 that must be
    // skipped, then the real Request and the end option.
    start_request(-1);
    pkt.push_back(OptPad);
    pkt.push_back(OptPad);
    pkt.push_back(8'd12);
    pkt.push_back(8'd1);
    pkt.push_back(8'h61);
    pkt.push_back(OptMsgType);
    pkt.push_back(8'd2);
    pkt.push_back(MsgDiscover);
    pkt.push_back(MsgRequest);
    add_type(MsgRequest);
    pkt.push_back(OptEnd);
    send_request();

    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d request packets (%0d bytes) under two register settings.",
             packets_sent, bytes_sent);
    $display("%0d replies were due and %0d reply words were compared.",
             sb.replies_due, sb.words_checked);
    if (sb.mismatches == 0 && sb.reply_words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // The slowest correct run is well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/dhcp_oar_pkg.sv
rtl/dhcp_offer_ack_responder.sv
test/dhcp_reply_check_pkg.sv
test/tb_dhcp_offer_ack_responder.sv
